/* sv/per_queue_packet_stats_macros.svh */
// ----------------------------------------------------------------------
// Assertion macros for the per-queue packet statistics block
// Shared property shapes, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------
`ifndef PER_QUEUE_PACKET_STATS_MACROS_SVH
`define PER_QUEUE_PACKET_STATS_MACROS_SVH

// Same-cycle implication: the consequent must hold when the antecedent does.
`define PQS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define PQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pqs_pkg.sv */
// ----------------------------------------------------------------------
// Per-queue packet statistics package
// Shared constants, codes and control types of the statistics block.
// ----------------------------------------------------------------------
package pqs_pkg;

  // Table geometry.
  localparam int NUM_QUEUES_DEF = 64;
  localparam int NUM_COUNTERS   = 12;
  localparam int CTR_W          = 64;
  localparam int ROW_W          = NUM_COUNTERS * CTR_W;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;
  localparam logic REG_DEV_HIGH = 1'b0;
  localparam logic REG_DEV_LOW  = 1'b1;

  // Operation codes.
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Counter positions within one queue row.
  localparam logic [3:0] C_BYTES = 4'd0;
  localparam logic [3:0] C_PKTS  = 4'd1;
  localparam logic [3:0] C_SYN   = 4'd2;
  localparam logic [3:0] C_BIN0  = 4'd3;
  localparam logic [3:0] C_BIN1  = 4'd4;
  localparam logic [3:0] C_BIN2  = 4'd5;
  localparam logic [3:0] C_BIN3  = 4'd6;
  localparam logic [3:0] C_BIN4  = 4'd7;
  localparam logic [3:0] C_TCP   = 4'd8;
  localparam logic [3:0] C_UDP   = 4'd9;
  localparam logic [3:0] C_ICMP  = 4'd10;
  localparam logic [3:0] C_OTHER = 4'd11;

  // Header field values.
  localparam logic [15:0] QUEUE_WILDCARD = 16'hffff;
  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] ETYPE_NONE     = 16'h0000;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Upper bounds of the length bins.
  localparam logic [31:0] LEN_LIM0 = 32'd64;
  localparam logic [31:0] LEN_LIM1 = 32'd512;
  localparam logic [31:0] LEN_LIM2 = 32'd2048;
  localparam logic [31:0] LEN_LIM3 = 32'd16384;
  localparam logic [31:0] LEN_LIM4 = 32'd65536;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_COUNTED       = 2'd0,
    STS_NAME_MISMATCH = 2'd1,
    STS_QUEUE_RANGE   = 2'd2,
    STS_READ_DONE     = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // One row of counters, as held in the counter memory.
  typedef logic [NUM_COUNTERS-1:0][CTR_W-1:0] row_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
  } ctrl_sts_t;

endpackage

/* sv/pqs_ram.sv */
// ----------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------
module pqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/pqs_regs.sv */
// ----------------------------------------------------------------------
// Configuration registers
// APB-style port holding the 128-bit device name to match.
// ----------------------------------------------------------------------
module pqs_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pqs_pkg::CFG_AW-1:0] paddr,
  input  logic [pqs_pkg::CFG_DW-1:0] pwdata,
  output logic [pqs_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output logic [63:0]                dev_name_high,
  output logic [63:0]                dev_name_low
);
  import pqs_pkg::*;

  logic [63:0] dev_high_r, dev_high_nxt;
  logic [63:0] dev_low_r, dev_low_nxt;
  logic        wr_en;
  logic        reg_sel;

  // Registers sit eight bytes apart, so the index is the top address bit.
  assign reg_sel = paddr[CFG_AW-1];
  assign wr_en   = psel && penable && pwrite;

  // Next values of the name registers.
  always_comb begin
    dev_high_nxt = dev_high_r;
    dev_low_nxt  = dev_low_r;
    if (wr_en) begin
      if (reg_sel == REG_DEV_LOW) begin
        dev_low_nxt = pwdata;
      end else begin
        dev_high_nxt = pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_high_r <= '0;
      dev_low_r  <= '0;
    end else begin
      dev_high_r <= dev_high_nxt;
      dev_low_r  <= dev_low_nxt;
    end
  end

  // Read back and outputs.
  assign prdata        = (reg_sel == REG_DEV_LOW) ? dev_low_r : dev_high_r;
  assign pready        = 1'b1;
  assign dev_name_high = dev_high_r;
  assign dev_name_low  = dev_low_r;

endmodule

/* sv/pqs_ctrl.sv */
// ----------------------------------------------------------------------
// Statistics controller
// Sequences the clearing pass and the read-modify-write of each word.
// ----------------------------------------------------------------------
module pqs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_stall,
  input  pqs_pkg::ctrl_sts_t    sts,
  output pqs_pkg::ctrl_cmd_t    cmd,
  output logic                  in_stall,
  output logic                  out_valid
);
  import pqs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can load when empty or when its word leaves now.
  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Output valid follows the commit and drops when the word is taken.
  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/pqs_dp.sv */
// ----------------------------------------------------------------------
// Statistics datapath
// Classifies each word, holds the counter memory and updates one row.
// ----------------------------------------------------------------------
module pqs_dp #(
  parameter int NUM_QUEUES = pqs_pkg::NUM_QUEUES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pqs_pkg::ctrl_cmd_t cmd,
  output pqs_pkg::ctrl_sts_t sts,
  input  logic [63:0]        dev_name_high,
  input  logic [63:0]        dev_name_low,
  input  logic               in_op,
  input  logic               in_is_receive,
  input  logic [63:0]        in_pkt_dev_high,
  input  logic [63:0]        in_pkt_dev_low,
  input  logic [15:0]        in_queue_number,
  input  logic [31:0]        in_pkt_length,
  input  logic [15:0]        in_ether_type,
  input  logic [7:0]         in_ip_protocol,
  input  logic               in_tcp_syn_flag,
  input  logic               in_tcp_ack_flag,
  input  logic [3:0]         in_counter_select,
  output logic [1:0]         out_status,
  output logic [63:0]        out_counter_value
);
  import pqs_pkg::*;

  localparam int ROWS   = 2 * NUM_QUEUES;
  localparam int ROW_AW = $clog2(ROWS);

  // Classification of the incoming word.
  logic [15:0]             queue_eff;
  logic                    in_range;
  logic [16:0]             row_full;
  logic [ROW_AW-1:0]       row_addr;
  logic                    name_ok;
  logic [7:0]              proto_eff;
  logic                    is_tcp, is_udp, is_icmp;
  status_t                 status_d;
  logic [NUM_COUNTERS-1:0] mask_d;

  // Captured word.
  status_t                 status_r;
  logic [3:0]              sel_r;
  logic [31:0]             len_r;
  logic [NUM_COUNTERS-1:0] mask_r;
  logic [ROW_AW-1:0]       row_addr_r;

  // Clearing pass address.
  logic [ROW_AW-1:0]       clr_addr_r, clr_addr_nxt;

  // Memory side.
  row_t                    row_old;
  row_t                    row_new;
  logic [ROW_W-1:0]        rdata;
  logic [ROW_W-1:0]        wdata;
  logic [ROW_AW-1:0]       waddr;
  logic                    we;

  // Result register.
  status_t                 out_status_r;
  logic [CTR_W-1:0]        out_value_r;
  logic                    sel_ok;

  // Receive events on the wildcard queue land on queue zero; reads do not remap.
  assign queue_eff = (in_op == OP_COUNT && in_is_receive && in_queue_number == QUEUE_WILDCARD)
                     ? 16'd0 : in_queue_number;
  assign in_range  = (queue_eff < 16'(NUM_QUEUES));
  assign row_full  = 17'(queue_eff) + (in_is_receive ? 17'(NUM_QUEUES) : 17'd0);
  assign row_addr  = row_full[ROW_AW-1:0];
  assign name_ok   = (in_pkt_dev_high == dev_name_high) && (in_pkt_dev_low == dev_name_low);

  // Status of the word, decided before the memory is touched.
  always_comb begin
    if (in_op == OP_READ) begin
      status_d = in_range ? STS_READ_DONE : STS_QUEUE_RANGE;
    end else if (!name_ok) begin
      status_d = STS_NAME_MISMATCH;
    end else if (!in_range) begin
      status_d = STS_QUEUE_RANGE;
    end else begin
      status_d = STS_COUNTED;
    end
  end

  // The IP protocol only counts for IPv4 frames.
  assign proto_eff = (in_ether_type == ETYPE_IPV4) ? in_ip_protocol : 8'd0;
  assign is_tcp    = (proto_eff == PROTO_TCP);
  assign is_udp    = (proto_eff == PROTO_UDP);
  assign is_icmp   = (proto_eff == PROTO_ICMP);

  // Mask of the counters that gain one for a counted packet.
  always_comb begin
    mask_d          = '0;
    mask_d[C_PKTS]  = 1'b1;
    mask_d[C_SYN]   = in_is_receive && in_tcp_syn_flag && !in_tcp_ack_flag;
    if (in_pkt_length < LEN_LIM0) begin
      mask_d[C_BIN0] = 1'b1;
    end else if (in_pkt_length < LEN_LIM1) begin
      mask_d[C_BIN1] = 1'b1;
    end else if (in_pkt_length < LEN_LIM2) begin
      mask_d[C_BIN2] = 1'b1;
    end else if (in_pkt_length < LEN_LIM3) begin
      mask_d[C_BIN3] = 1'b1;
    end else if (in_pkt_length < LEN_LIM4) begin
      mask_d[C_BIN4] = 1'b1;
    end
    mask_d[C_TCP]   = is_tcp;
    mask_d[C_UDP]   = is_udp;
    mask_d[C_ICMP]  = is_icmp;
    mask_d[C_OTHER] = !is_tcp && !is_udp && !is_icmp && (in_ether_type != ETYPE_NONE);
  end

  // Capture the word while the memory row is being read.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_r   <= status_d;
      sel_r      <= in_counter_select;
      len_r      <= in_pkt_length;
      mask_r     <= mask_d;
      row_addr_r <= row_addr;
    end
  end

  // Clearing pass walks every row once after reset.
  assign clr_addr_nxt   = cmd.clear_step ? clr_addr_r + ROW_AW'(1) : clr_addr_r;
  assign sts.clear_last = (clr_addr_r == ROW_AW'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Updated row: bytes add the length, the rest add their mask bit.
  assign row_old = rdata;

  always_comb begin
    row_new = row_old;
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      row_new[k] = row_old[k] + CTR_W'(mask_r[k]);
    end
    row_new[C_BYTES] = row_old[C_BYTES] + CTR_W'(len_r);
  end

  // Memory write: zeros during the clearing pass, else the updated row.
  assign we    = cmd.clear_step || (cmd.commit && status_r == STS_COUNTED);
  assign waddr = cmd.clear_step ? clr_addr_r : row_addr_r;
  assign wdata = cmd.clear_step ? '0 : row_new;

  pqs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.capture),
    .raddr (row_addr),
    .rdata (rdata)
  );

  // Result register loads at commit.
  assign sel_ok = (sel_r < 4'(NUM_COUNTERS));

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_r;
      if (status_r == STS_READ_DONE && sel_ok) begin
        out_value_r <= row_old[sel_r];
      end else begin
        out_value_r <= '0;
      end
    end
  end

  assign out_status        = out_status_r;
  assign out_counter_value = out_value_r;

endmodule

/* sv/per_queue_packet_stats.sv */
// ----------------------------------------------------------------------
// Per-queue packet statistics counters
// Twelve wrapping 64-bit counters per queue for transmit and receive,
// updated by packet words whose device name matches, read one at a time.
// ----------------------------------------------------------------------
//
//  Channel   Direction  Handshake         Carries
//  in_       input      in_valid/in_stall  one packet event or counter read
//  out_      output     out_valid/out_stall status and counter value
//  cfg       input      APB psel/penable   device name to match (two words)
//
//  Each word first reads the queue's counter row from the memory as it is
//  captured, then writes the updated row back and loads the result register
//  once that register is free; no new word is taken until then.
//  After reset a clearing pass zeroes all 2*NUM_QUEUES rows of the memory; no
//  word is taken during it, but configuration writes are.
//  A result waits in its register while out_stall is high; the next word may
//  be taken meanwhile, and its update holds until the register frees up.
//
module per_queue_packet_stats #(
  parameter int NUM_QUEUES = pqs_pkg::NUM_QUEUES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic                       in_is_receive,
  input  logic [63:0]                in_pkt_dev_high,
  input  logic [63:0]                in_pkt_dev_low,
  input  logic [15:0]                in_queue_number,
  input  logic [31:0]                in_pkt_length,
  input  logic [15:0]                in_ether_type,
  input  logic [7:0]                 in_ip_protocol,
  input  logic                       in_tcp_syn_flag,
  input  logic                       in_tcp_ack_flag,
  input  logic [3:0]                 in_counter_select,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [63:0]                out_counter_value,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pqs_pkg::CFG_AW-1:0] paddr,
  input  logic [pqs_pkg::CFG_DW-1:0] pwdata,
  output logic [pqs_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import pqs_pkg::*;

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  logic [63:0] dev_name_high;
  logic [63:0] dev_name_low;

  // Configuration registers.
  pqs_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .dev_name_high (dev_name_high),
    .dev_name_low  (dev_name_low)
  );

  // Controller.
  pqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // Datapath with the counter memory.
  pqs_dp #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .dev_name_high     (dev_name_high),
    .dev_name_low      (dev_name_low),
    .in_op             (in_op),
    .in_is_receive     (in_is_receive),
    .in_pkt_dev_high   (in_pkt_dev_high),
    .in_pkt_dev_low    (in_pkt_dev_low),
    .in_queue_number   (in_queue_number),
    .in_pkt_length     (in_pkt_length),
    .in_ether_type     (in_ether_type),
    .in_ip_protocol    (in_ip_protocol),
    .in_tcp_syn_flag   (in_tcp_syn_flag),
    .in_tcp_ack_flag   (in_tcp_ack_flag),
    .in_counter_select (in_counter_select),
    .out_status        (out_status),
    .out_counter_value (out_counter_value)
  );

endmodule

/* sv/pqs_checker.sv */
// ----------------------------------------------------------------------
// Statistics block checker
// Port-level assertions on word sequencing and result contents.
// ----------------------------------------------------------------------
`include "per_queue_packet_stats_macros.svh"

module pqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [63:0] out_counter_value
);
  import pqs_pkg::*;

  // One word at a time: the input closes right after a word is taken.
  `PQS_ASSERT_NEXT(a_one_word_in_flight, in_valid && !in_stall, in_stall, "word taken while busy")

  // A fresh result rises only for a word taken earlier, through the update state and the output valid register.
  `PQS_ASSERT_IMPL(a_result_follows_word, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without a word")

  // Only a completed read carries a counter value.
  `PQS_ASSERT_IMPL(a_value_only_on_read, out_valid && out_status != STS_READ_DONE, out_counter_value == 64'd0, "nonzero value on non-read")

  // A stalled result holds.
  `PQS_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_counter_value), "stalled result changed")

endmodule

bind per_queue_packet_stats pqs_checker u_pqs_checker (.*);

/* verif/per_queue_packet_stats_tb.sv */
// ----------------------------------------------------------------------
// Testbench for the per-queue packet statistics counters
// Sends packet and read words through the valid/stall channel. It sets
// the device name over the APB port, and mirrors the twelve counters of
// every queue to work out each expected status and counter value.
// ----------------------------------------------------------------------
module per_queue_packet_stats_tb;
  import pqs_pkg::*;

  localparam int NQ         = NUM_QUEUES_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_WORDS = 170;

  // One input word, field by field.
  typedef struct packed {
    logic        op;
    logic        is_rx;
    logic [63:0] dev_hi;
    logic [63:0] dev_lo;
    logic [15:0] queue;
    logic [31:0] len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic        syn;
    logic        ack;
    logic [3:0]  sel;
  } stats_word_t;

  // One result word.
  typedef struct packed {
    status_t     status;
    logic [63:0] value;
  } stats_result_t;

  // Directed row. Rows with a typed status expect a zero counter value.
  typedef struct packed {
    logic        op;
    logic        is_rx;
    logic        name_ok;
    logic [15:0] queue;
    logic [31:0] len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic        syn;
    logic        ack;
    logic [3:0]  sel;
    logic        typed;
    status_t     typed_status;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [26] = '{
    // Reads straight after reset, out-of-range queues, unused selects.
    '{OP_READ,  0, 1, 16'd0,      32'd0,      ETYPE_NONE, 8'd0,       0, 0, C_BYTES, 1, STS_READ_DONE},
    '{OP_READ,  0, 1, 16'd64,     32'd0,      ETYPE_NONE, 8'd0,       0, 0, C_PKTS,  1, STS_QUEUE_RANGE},
    '{OP_READ,  1, 1, 16'hffff,   32'd0,      ETYPE_NONE, 8'd0,       0, 0, C_PKTS,  1, STS_QUEUE_RANGE},
    '{OP_READ,  0, 1, 16'd0,      32'd0,      ETYPE_NONE, 8'd0,       0, 0, 4'd15,   1, STS_READ_DONE},
    // Name mismatches on queue zero, then matching names on out-of-range queues.
    '{OP_COUNT, 0, 0, 16'd0,      32'd100,    ETYPE_IPV4, PROTO_TCP,  0, 0, C_BYTES, 1, STS_NAME_MISMATCH},
    '{OP_COUNT, 1, 0, 16'hffff,   32'd100,    ETYPE_IPV4, PROTO_TCP,  0, 0, C_BYTES, 1, STS_NAME_MISMATCH},
    '{OP_COUNT, 0, 1, 16'd64,     32'd100,    ETYPE_IPV4, PROTO_TCP,  0, 0, C_BYTES, 1, STS_QUEUE_RANGE},
    '{OP_COUNT, 0, 1, 16'hffff,   32'd100,    ETYPE_IPV4, PROTO_TCP,  0, 0, C_BYTES, 1, STS_QUEUE_RANGE},
    // Length bin edges and protocol classes on transmit queue zero, the last on queue 63.
    '{OP_COUNT, 0, 1, 16'd0,      32'd0,      ETYPE_NONE, 8'd0,       0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd63,     ETYPE_IPV4, PROTO_TCP,  0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd64,     ETYPE_IPV4, PROTO_UDP,  0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd511,    ETYPE_IPV4, PROTO_ICMP, 0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd512,    ETYPE_IPV4, 8'd255,     0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd2047,   16'h86dd,   PROTO_TCP,  0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd2048,   ETYPE_NONE, PROTO_UDP,  0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd16383,  16'hffff,   8'd0,       0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd16384,  ETYPE_IPV4, PROTO_TCP,  1, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd65535,  ETYPE_IPV4, PROTO_TCP,  0, 1, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd0,      32'd65536,  ETYPE_IPV4, PROTO_UDP,  0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 0, 1, 16'd63,     32'hffffffff, ETYPE_IPV4, PROTO_ICMP, 1, 1, C_BYTES, 0, STS_COUNTED},
    // Receive wildcard queue and the SYN-without-ACK rule.
    '{OP_COUNT, 1, 1, 16'hffff,   32'd60,     ETYPE_IPV4, PROTO_TCP,  1, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_COUNT, 1, 1, 16'd63,     32'd1500,   ETYPE_IPV4, PROTO_TCP,  1, 1, C_BYTES, 0, STS_COUNTED},
    // Read back what the rows above built up.
    '{OP_READ,  0, 1, 16'd0,      32'd0,      ETYPE_NONE, 8'd0,       0, 0, C_BYTES, 0, STS_COUNTED},
    '{OP_READ,  0, 1, 16'd0,      32'd0,      ETYPE_NONE, 8'd0,       0, 0, C_OTHER, 0, STS_COUNTED},
    '{OP_READ,  1, 1, 16'd0,      32'd0,      ETYPE_NONE, 8'd0,       0, 0, C_SYN,   0, STS_COUNTED},
    '{OP_READ,  0, 1, 16'd63,     32'd0,      ETYPE_NONE, 8'd0,       0, 0, C_BYTES, 0, STS_COUNTED}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic        in_is_receive;
  logic [63:0] in_pkt_dev_high;
  logic [63:0] in_pkt_dev_low;
  logic [15:0] in_queue_number;
  logic [31:0] in_pkt_length;
  logic [15:0] in_ether_type;
  logic [7:0]  in_ip_protocol;
  logic        in_tcp_syn_flag;
  logic        in_tcp_ack_flag;
  logic [3:0]  in_counter_select;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_counter_value;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Mirror of the block: configured name and every counter.
  logic [63:0] name_hi_cfg;
  logic [63:0] name_lo_cfg;
  logic [63:0] ctr_mirror [2][NQ][NUM_COUNTERS];

  stats_result_t pending_results [$];
  stats_result_t head_result;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int n_words       = 0;
  int n_reads       = 0;
  int n_results     = 0;
  int n_nonzero     = 0;
  int quiet_cycles  = 0;

  per_queue_packet_stats #(.NUM_QUEUES(NQ)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_is_receive     (in_is_receive),
    .in_pkt_dev_high   (in_pkt_dev_high),
    .in_pkt_dev_low    (in_pkt_dev_low),
    .in_queue_number   (in_queue_number),
    .in_pkt_length     (in_pkt_length),
    .in_ether_type     (in_ether_type),
    .in_ip_protocol    (in_ip_protocol),
    .in_tcp_syn_flag   (in_tcp_syn_flag),
    .in_tcp_ack_flag   (in_tcp_ack_flag),
    .in_counter_select (in_counter_select),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_counter_value (out_counter_value),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s: got %h, want %h", $time, what, got, want);
    fail_count++;
  endtask

  // Applies one word to the mirror and returns the result it causes.
  function automatic stats_result_t apply_word(input stats_word_t w);
    stats_result_t r;
    logic [15:0]   q;
    logic [7:0]    proto;
    r.status = STS_COUNTED;
    r.value  = '0;
    if (w.op == OP_READ) begin
      if (w.queue >= NQ) begin
        r.status = STS_QUEUE_RANGE;
      end else begin
        r.status = STS_READ_DONE;
        if (w.sel < NUM_COUNTERS) r.value = ctr_mirror[w.is_rx][w.queue][w.sel];
      end
      return r;
    end
    if (w.dev_hi != name_hi_cfg || w.dev_lo != name_lo_cfg) begin
      r.status = STS_NAME_MISMATCH;
      return r;
    end
    // The receive wildcard folds onto queue zero.
    q = (w.is_rx && w.queue == QUEUE_WILDCARD) ? 16'd0 : w.queue;
    if (q >= NQ) begin
      r.status = STS_QUEUE_RANGE;
      return r;
    end
    ctr_mirror[w.is_rx][q][C_BYTES] += {32'd0, w.len};
    ctr_mirror[w.is_rx][q][C_PKTS]  += 64'd1;
    if (w.is_rx && w.syn && !w.ack) ctr_mirror[w.is_rx][q][C_SYN] += 64'd1;
    // Lengths of 64 KiB and above fall into no bin.
    if (w.len < LEN_LIM0)      ctr_mirror[w.is_rx][q][C_BIN0] += 64'd1;
    else if (w.len < LEN_LIM1) ctr_mirror[w.is_rx][q][C_BIN1] += 64'd1;
    else if (w.len < LEN_LIM2) ctr_mirror[w.is_rx][q][C_BIN2] += 64'd1;
    else if (w.len < LEN_LIM3) ctr_mirror[w.is_rx][q][C_BIN3] += 64'd1;
    else if (w.len < LEN_LIM4) ctr_mirror[w.is_rx][q][C_BIN4] += 64'd1;
    // The protocol byte only means something for IPv4.
    proto = (w.etype == ETYPE_IPV4) ? w.proto : 8'd0;
    if (proto == PROTO_TCP)       ctr_mirror[w.is_rx][q][C_TCP]   += 64'd1;
    else if (proto == PROTO_UDP)  ctr_mirror[w.is_rx][q][C_UDP]   += 64'd1;
    else if (proto == PROTO_ICMP) ctr_mirror[w.is_rx][q][C_ICMP]  += 64'd1;
    else if (w.etype != ETYPE_NONE) ctr_mirror[w.is_rx][q][C_OTHER] += 64'd1;
    return r;
  endfunction

  // Random word: mostly matching packets on a few hot queues, plus reads.
  function automatic stats_word_t random_word();
    stats_word_t w;
    w.op     = ($urandom_range(99) < 30) ? OP_READ : OP_COUNT;
    w.is_rx  = 1'($urandom_range(1));
    w.syn    = 1'($urandom_range(1));
    w.ack    = 1'($urandom_range(1));
    w.sel    = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
    case ($urandom_range(9))
      0:       w.queue = 16'($urandom);
      1:       w.queue = QUEUE_WILDCARD;
      2, 3, 4: w.queue = 16'($urandom_range(NQ - 1));
      default: w.queue = 16'($urandom_range(3));
    endcase
    w.dev_hi = name_hi_cfg;
    w.dev_lo = name_lo_cfg;
    if (w.op == OP_READ || $urandom_range(9) == 0) begin
      // Reads ignore the name; on packets this is a mismatch, usually.
      case ($urandom_range(2))
        0:       w.dev_hi ^= 64'd1 << $urandom_range(63);
        1:       w.dev_lo ^= 64'd1 << $urandom_range(63);
        default: begin
          w.dev_hi = {$urandom, $urandom};
          w.dev_lo = {$urandom, $urandom};
        end
      endcase
    end
    case ($urandom_range(7))
      0:       w.len = $urandom_range(63);
      1:       w.len = $urandom_range(511, 64);
      2:       w.len = $urandom_range(2047, 512);
      3:       w.len = $urandom_range(16383, 2048);
      4:       w.len = $urandom_range(65535, 16384);
      5:       w.len = $urandom_range(1 << 20, 65536);
      default: w.len = $urandom;
    endcase
    case ($urandom_range(9))
      6:       w.etype = ETYPE_NONE;
      7, 8, 9: w.etype = 16'($urandom);
      default: w.etype = ETYPE_IPV4;
    endcase
    case ($urandom_range(3))
      0:       w.proto = PROTO_TCP;
      1:       w.proto = PROTO_UDP;
      2:       w.proto = PROTO_ICMP;
      default: w.proto = 8'($urandom);
    endcase
    return w;
  endfunction

  // APB write followed by a read-back of the same register.
  task automatic cfg_write(input logic reg_idx, input logic [63:0] value);
    logic [63:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_DEV_HIGH) name_hi_cfg = value;
    else name_lo_cfg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) report_mismatch("register read-back", readback, value);
  endtask

  // Random sender gaps; valid stays low through each idle cycle.
  task automatic sender_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Drives one word, waits for it to be taken and queues its result.
  task automatic send_word(input stats_word_t w, input logic typed,
                           input status_t typed_status);
    stats_result_t r;
    @(negedge clk);
    in_valid          <= 1'b1;
    in_op             <= w.op;
    in_is_receive     <= w.is_rx;
    in_pkt_dev_high   <= w.dev_hi;
    in_pkt_dev_low    <= w.dev_lo;
    in_queue_number   <= w.queue;
    in_pkt_length     <= w.len;
    in_ether_type     <= w.etype;
    in_ip_protocol    <= w.proto;
    in_tcp_syn_flag   <= w.syn;
    in_tcp_ack_flag   <= w.ack;
    in_counter_select <= w.sel;
    do @(posedge clk); while (in_stall);
    r = apply_word(w);
    if (typed) begin
      r.status = typed_status;
      r.value  = '0;
    end
    pending_results.push_back(r);
    n_words++;
    if (w.op == OP_READ) n_reads++;
  endtask

  // Lets every pending result arrive, then a few more cycles.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", out_counter_value, 64'd0);
      end else begin
        head_result = pending_results.pop_front();
        if (out_status !== head_result.status)
          report_mismatch("status", 64'(out_status), 64'(head_result.status));
        if (out_counter_value !== head_result.value)
          report_mismatch("counter value", out_counter_value, head_result.value);
        if (head_result.value != 64'd0) n_nonzero++;
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    stats_word_t w;
    dir_row_t    row;
    logic [63:0] hi_val;
    logic [63:0] lo_val;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_op             = OP_COUNT;
    in_is_receive     = 1'b0;
    in_pkt_dev_high   = '0;
    in_pkt_dev_low    = '0;
    in_queue_number   = '0;
    in_pkt_length     = '0;
    in_ether_type     = '0;
    in_ip_protocol    = '0;
    in_tcp_syn_flag   = 1'b0;
    in_tcp_ack_flag   = 1'b0;
    in_counter_select = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    name_hi_cfg       = '0;
    name_lo_cfg       = '0;
    for (int t = 0; t < 2; t++)
      for (int q = 0; q < NQ; q++)
        for (int c = 0; c < NUM_COUNTERS; c++) ctr_mirror[t][q][c] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows run against the reset name of all zeros.
    send_idle_pct = 37;
    recv_idle_pct = 83;
    foreach (DIR_ROWS[i]) begin
      row      = DIR_ROWS[i];
      w.op     = row.op;
      w.is_rx  = row.is_rx;
      w.dev_hi = row.name_ok ? name_hi_cfg : ~name_hi_cfg;
      w.dev_lo = name_lo_cfg;
      w.queue  = row.queue;
      w.len    = row.len;
      w.etype  = row.etype;
      w.proto  = row.proto;
      w.syn    = row.syn;
      w.ack    = row.ack;
      w.sel    = row.sel;
      sender_gap();
      send_word(w, row.typed, row.typed_status);
    end

    // Random segments, each with its own device name and idling mix.
    for (int seg = 0; seg < 3; seg++) begin
      drain();
      case (seg)
        0: begin
          hi_val = '1;
          lo_val = '1;
        end
        1: begin
          hi_val = {$urandom, $urandom};
          lo_val = {$urandom, $urandom};
          send_idle_pct = 83;
          recv_idle_pct = 37;
        end
        default: begin
          hi_val = {$urandom, $urandom};
          lo_val = '0;
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      cfg_write(REG_DEV_HIGH, hi_val);
      cfg_write(REG_DEV_LOW, lo_val);
      repeat (RAND_WORDS) begin
        sender_gap();
        send_word(random_word(), 1'b0, STS_COUNTED);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d words (%0d counter reads) and %0d checked results, %0d nonzero.",
             n_words, n_reads, n_results, n_nonzero);
    $display("Device names: reset zeros, all ones and two random; idling mixes: three.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
